// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared widths, constants and helpers for the point bearing angle pipeline.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int PBA_COORD_WIDTH     = 24;
    localparam int PBA_ANGLE_FRAC_BITS = 8;
    localparam int PBA_CORDIC_STAGES   = 16;

    // Result field widths: 180 degrees needs 8 integer bits and 90 degrees 7, plus a sign.
    localparam int AZ_W = PBA_ANGLE_FRAC_BITS + 9;
    localparam int EL_W = PBA_ANGLE_FRAC_BITS + 8;

    // CORDIC operand width, elevation normalised coordinate width.
    localparam int OP_W    = 33;
    localparam int NRM_W   = 32;
    localparam int NRM_MSB = 29;

    // Square root: radicand and root widths.
    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = 31;

    // CORDIC datapath, angle accumulator (2^-32 turn) and normalisation target.
    localparam int CV_W   = 44;
    localparam int CV_MSB = 39;
    localparam int ANG_W  = 34;
    localparam int LOG_W  = 6;

    localparam logic signed [ANG_W-1:0] TURN_HALF    = ANG_W'(64'h0000_0000_8000_0000);
    localparam logic signed [ANG_W-1:0] TURN_QUARTER = ANG_W'(64'h0000_0000_4000_0000);

    // 360 degrees per 2^32 turn equals 45 per 2^29.
    localparam int DEG_SCALE    = 45;
    localparam int ROUND_SHIFT  = 29;
    localparam int AZ_LIMIT_DEG = 180;
    localparam int EL_LIMIT_DEG = 90;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [OP_W-1:0]  az_y;
        logic signed [OP_W-1:0]  az_x;
        logic signed [NRM_W-1:0] el_y;
        logic                    zero;
    } t_side;

    // Position of the highest set bit; zero for an all-zero word.
    function automatic logic [LOG_W-1:0] lead_one(input logic [OP_W-1:0] v);
        logic [LOG_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < OP_W; i++) begin
            if (v[i]) begin
                pos = LOG_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/pba_if.sv =====
// ----------------------------------------------------------------------------
// pba_if
// Valid/ready channels for points in and bearing results out.
// ----------------------------------------------------------------------------
interface pba_in_if
    import pba_pkg::*;
();
    logic                              valid;
    logic                              ready;
    logic signed [PBA_COORD_WIDTH-1:0] point_x;
    logic signed [PBA_COORD_WIDTH-1:0] point_y;
    logic signed [PBA_COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface pba_out_if
    import pba_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [AZ_W-1:0] azimuth_deg;
    logic signed [EL_W-1:0] elevation_deg;
    logic                   zero_point;

    modport source (output valid, output azimuth_deg, output elevation_deg,
                    output zero_point, input ready);
    modport sink   (input valid, input azimuth_deg, input elevation_deg,
                    input zero_point, output ready);
endinterface

// ===== rtl/pba_prep.sv =====
// ----------------------------------------------------------------------------
// pba_prep
// Front end: sign extension, common scaling of x, y, z for the elevation
// path, and the sum of squares x*x + z*z. Five register stages.
// ----------------------------------------------------------------------------
module pba_prep
    import pba_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_vld,
    input  logic signed [PBA_COORD_WIDTH-1:0] i_x,
    input  logic signed [PBA_COORD_WIDTH-1:0] i_y,
    input  logic signed [PBA_COORD_WIDTH-1:0] i_z,
    output logic                              o_vld,
    output t_side                             o_side,
    output logic [SQ_IN_W-1:0]                o_sum
);

    localparam int EXT_W  = OP_W - PBA_COORD_WIDTH;
    localparam int WIDE_W = OP_W + NRM_MSB;

    function automatic logic [OP_W-1:0] mag(input logic signed [OP_W-1:0] v);
        return v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
    endfunction

    function automatic logic signed [NRM_W-1:0] scale(input logic signed [OP_W-1:0] v,
                                                      input logic [4:0] lsh,
                                                      input logic [4:0] rsh);
        logic signed [WIDE_W-1:0] w;
        w = {{NRM_MSB{v[OP_W-1]}}, v};
        w = w <<< lsh;
        w = w >>> rsh;
        return w[NRM_W-1:0];
    endfunction

    logic [5:1] r_vld;

    // Stage 1
    logic signed [OP_W-1:0] n1_x, n1_y, n1_z;
    logic [OP_W-1:0]        n1_m;
    logic signed [OP_W-1:0] r1_x, r1_y, r1_z;
    logic [OP_W-1:0]        r1_m;
    logic                   r1_zero;

    // Stage 2
    logic [LOG_W-1:0]       msb2;
    logic [4:0]             n2_lsh, n2_rsh;
    logic signed [OP_W-1:0] r2_x, r2_y, r2_z;
    logic [4:0]             r2_lsh, r2_rsh;
    logic                   r2_zero;

    // Stage 3
    logic signed [NRM_W-1:0] r3_xs, r3_ys, r3_zs;
    logic signed [OP_W-1:0]  r3_x, r3_z;
    logic                    r3_zero;

    // Stage 4
    logic signed [2*NRM_W-1:0] sq_x, sq_z;
    logic [SQ_IN_W-1:0]        r4_xx, r4_zz;
    logic signed [NRM_W-1:0]   r4_ys;
    logic signed [OP_W-1:0]    r4_x, r4_z;
    logic                      r4_zero;

    // Stage 5
    logic [SQ_IN_W-1:0] r5_sum;
    t_side              r5_side;

    always_comb begin
        n1_x = {{EXT_W{i_x[PBA_COORD_WIDTH-1]}}, i_x};
        n1_y = {{EXT_W{i_y[PBA_COORD_WIDTH-1]}}, i_y};
        n1_z = {{EXT_W{i_z[PBA_COORD_WIDTH-1]}}, i_z};
        n1_m = mag(n1_x);
        if (mag(n1_y) > n1_m) begin
            n1_m = mag(n1_y);
        end
        if (mag(n1_z) > n1_m) begin
            n1_m = mag(n1_z);
        end
    end

    // Bring the largest magnitude into [2^29, 2^30).
    always_comb begin
        msb2   = lead_one(r1_m);
        n2_lsh = (msb2 < LOG_W'(NRM_MSB)) ? 5'(LOG_W'(NRM_MSB) - msb2) : '0;
        n2_rsh = (msb2 > LOG_W'(NRM_MSB)) ? 5'(msb2 - LOG_W'(NRM_MSB)) : '0;
    end

    assign sq_x = r3_xs * r3_xs;
    assign sq_z = r3_zs * r3_zs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_x    <= n1_x;
            r1_y    <= n1_y;
            r1_z    <= n1_z;
            r1_m    <= n1_m;
            r1_zero <= (n1_m == '0);

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_lsh  <= n2_lsh;
            r2_rsh  <= n2_rsh;
            r2_zero <= r1_zero;

            r3_xs   <= scale(r2_x, r2_lsh, r2_rsh);
            r3_ys   <= scale(r2_y, r2_lsh, r2_rsh);
            r3_zs   <= scale(r2_z, r2_lsh, r2_rsh);
            r3_x    <= r2_x;
            r3_z    <= r2_z;
            r3_zero <= r2_zero;

            r4_xx   <= sq_x[SQ_IN_W-1:0];
            r4_zz   <= sq_z[SQ_IN_W-1:0];
            r4_ys   <= r3_ys;
            r4_x    <= r3_x;
            r4_z    <= r3_z;
            r4_zero <= r3_zero;

            r5_sum       <= r4_xx + r4_zz;
            r5_side.az_y <= r4_x;
            r5_side.az_x <= r4_z;
            r5_side.el_y <= r4_ys;
            r5_side.zero <= r4_zero;
        end
    end

    assign o_vld  = r_vld[5];
    assign o_side = r5_side;
    assign o_sum  = r5_sum;

endmodule

// ===== rtl/pba_isqrt.sv =====
// ----------------------------------------------------------------------------
// pba_isqrt
// Pipelined floor square root, one root bit per register stage. The side
// payload travels alongside.
// ----------------------------------------------------------------------------
module pba_isqrt
    import pba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_vld,
    input  logic [SQ_IN_W-1:0]  i_rad,
    input  t_side               i_side,
    output logic                o_vld,
    output logic [SQ_OUT_W-1:0] o_root,
    output t_side               o_side
);

    logic [SQ_IN_W-1:0]  n_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] n_root [SQ_OUT_W];
    t_side               n_side [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  r_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_root [SQ_OUT_W];
    t_side               r_side [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_vld;

    for (genvar gk = 0; gk < SQ_OUT_W; gk++) begin : g_bit
        localparam int B = SQ_OUT_W - 1 - gk;
        logic [SQ_IN_W-1:0]  rem_src;
        logic [SQ_OUT_W-1:0] root_src;
        logic [SQ_IN_W-1:0]  trial;
        logic                fits;

        if (gk == 0) begin : g_first
            assign rem_src    = i_rad;
            assign root_src   = '0;
            assign n_side[gk] = i_side;
        end else begin : g_next
            assign rem_src    = r_rem[gk-1];
            assign root_src   = r_root[gk-1];
            assign n_side[gk] = r_side[gk-1];
        end

        // The partial root has no bits at or below B, so the OR is an add.
        assign trial = (SQ_IN_W'(root_src) << (B + 1)) | (SQ_IN_W'(1) << (2 * B));
        assign fits  = (rem_src >= trial);
        assign n_rem[gk]  = fits ? rem_src - trial : rem_src;
        assign n_root[gk] = fits ? root_src | (SQ_OUT_W'(1) << B) : root_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[SQ_OUT_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld[SQ_OUT_W-1];
    assign o_root = r_root[SQ_OUT_W-1];
    assign o_side = r_side[SQ_OUT_W-1];

endmodule

// ===== rtl/pba_cordic.sv =====
// ----------------------------------------------------------------------------
// pba_cordic
// Vectoring CORDIC giving atan2(y, x) in 2^-32 turn. Three stages of
// quadrant folding and normalisation, then one stage per micro-rotation.
// ----------------------------------------------------------------------------
module pba_cordic
    import pba_pkg::*;
#(
    parameter int CORDIC_STAGES = PBA_CORDIC_STAGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_vld,
    input  logic signed [OP_W-1:0]  i_yv,
    input  logic signed [OP_W-1:0]  i_xv,
    input  logic                    i_zero,
    output logic                    o_vld,
    output logic signed [ANG_W-1:0] o_ang,
    output logic                    o_zero
);

    // Stage A: special cases and fold into the right half plane.
    logic signed [OP_W-1:0]  n_a_y, n_a_x;
    logic signed [ANG_W-1:0] n_a_ang;
    logic                    n_a_hold;
    logic signed [OP_W-1:0]  r_a_y, r_a_x;
    logic signed [ANG_W-1:0] r_a_ang;
    logic                    r_a_hold, r_a_zero, r_a_vld;

    // Stage B: shift amount.
    logic [OP_W-1:0]         a_my, a_m;
    logic [LOG_W-1:0]        a_msb;
    logic signed [OP_W-1:0]  r_b_y, r_b_x;
    logic signed [ANG_W-1:0] r_b_ang;
    logic [LOG_W-1:0]        r_b_sh;
    logic                    r_b_hold, r_b_zero, r_b_vld;

    // Stage C: normalised operands.
    logic signed [CV_W-1:0]  r_c_y, r_c_x;
    logic signed [ANG_W-1:0] r_c_ang;
    logic                    r_c_hold, r_c_zero, r_c_vld;

    // Micro-rotations.
    logic signed [CV_W-1:0]  n_x [CORDIC_STAGES];
    logic signed [CV_W-1:0]  n_y [CORDIC_STAGES];
    logic signed [ANG_W-1:0] n_ang [CORDIC_STAGES];
    logic signed [CV_W-1:0]  r_x [CORDIC_STAGES];
    logic signed [CV_W-1:0]  r_y [CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_ang [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] r_hold, r_zero, r_vld;

    always_comb begin
        n_a_y    = i_yv;
        n_a_x    = i_xv;
        n_a_ang  = '0;
        n_a_hold = 1'b0;
        if (i_yv == '0) begin
            n_a_hold = 1'b1;
            n_a_ang  = i_xv[OP_W-1] ? TURN_HALF : '0;
        end else if (i_xv == '0) begin
            n_a_hold = 1'b1;
            n_a_ang  = i_yv[OP_W-1] ? -TURN_QUARTER : TURN_QUARTER;
        end else if (i_xv[OP_W-1]) begin
            n_a_ang = i_yv[OP_W-1] ? -TURN_HALF : TURN_HALF;
            n_a_y   = -i_yv;
            n_a_x   = -i_xv;
        end
    end

    always_comb begin
        a_my  = r_a_y[OP_W-1] ? OP_W'(-r_a_y) : OP_W'(r_a_y);
        a_m   = (OP_W'(r_a_x) > a_my) ? OP_W'(r_a_x) : a_my;
        a_msb = lead_one(a_m);
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_iter
        logic signed [CV_W-1:0]  src_x, src_y, dx, dy;
        logic signed [ANG_W-1:0] src_ang;
        logic [ANG_W-1:0]        step;
        logic                    src_hold;

        if (gi == 0) begin : g_first
            assign src_x    = r_c_x;
            assign src_y    = r_c_y;
            assign src_ang  = r_c_ang;
            assign src_hold = r_c_hold;
        end else begin : g_next
            assign src_x    = r_x[gi-1];
            assign src_y    = r_y[gi-1];
            assign src_ang  = r_ang[gi-1];
            assign src_hold = r_hold[gi-1];
        end

        assign dx   = src_y >>> gi;
        assign dy   = src_x >>> gi;
        assign step = ANG_W'(ATAN_TURN[gi]);

        assign n_x[gi]   = src_hold ? src_x :
                           (src_y[CV_W-1] ? src_x - dx : src_x + dx);
        assign n_y[gi]   = src_hold ? src_y :
                           (src_y[CV_W-1] ? src_y + dy : src_y - dy);
        assign n_ang[gi] = src_hold ? src_ang :
                           (src_y[CV_W-1] ? src_ang - step : src_ang + step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_vld   <= '0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_vld   <= {r_vld[CORDIC_STAGES-2:0], r_c_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_y    <= n_a_y;
            r_a_x    <= n_a_x;
            r_a_ang  <= n_a_ang;
            r_a_hold <= n_a_hold;
            r_a_zero <= i_zero;

            r_b_y    <= r_a_y;
            r_b_x    <= r_a_x;
            r_b_ang  <= r_a_ang;
            r_b_sh   <= (a_msb < LOG_W'(CV_MSB)) ? LOG_W'(CV_MSB) - a_msb : '0;
            r_b_hold <= r_a_hold;
            r_b_zero <= r_a_zero;

            r_c_y    <= {{(CV_W-OP_W){r_b_y[OP_W-1]}}, r_b_y} <<< r_b_sh;
            r_c_x    <= {{(CV_W-OP_W){r_b_x[OP_W-1]}}, r_b_x} <<< r_b_sh;
            r_c_ang  <= r_b_ang;
            r_c_hold <= r_b_hold;
            r_c_zero <= r_b_zero;

            r_x    <= n_x;
            r_y    <= n_y;
            r_ang  <= n_ang;
            r_hold <= {r_hold[CORDIC_STAGES-2:0], r_c_hold};
            r_zero <= {r_zero[CORDIC_STAGES-2:0], r_c_zero};
        end
    end

    assign o_vld  = r_vld[CORDIC_STAGES-1];
    assign o_ang  = r_ang[CORDIC_STAGES-1];
    assign o_zero = r_zero[CORDIC_STAGES-1];

endmodule

// ===== rtl/pba_deg.sv =====
// ----------------------------------------------------------------------------
// pba_deg
// Converts both angles from 2^-32 turn to rounded, clamped Q degrees.
// Two register stages; the second is the result register.
// ----------------------------------------------------------------------------
module pba_deg
    import pba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_vld,
    input  logic signed [ANG_W-1:0] i_az,
    input  logic signed [ANG_W-1:0] i_el,
    input  logic                    i_zero,
    output logic                    o_vld,
    output logic signed [AZ_W-1:0]  o_az,
    output logic signed [EL_W-1:0]  o_el,
    output logic                    o_zero
);

    localparam int PROD_W = ANG_W + 6;
    localparam int RW     = PROD_W + PBA_ANGLE_FRAC_BITS;
    localparam int QW     = RW + 1 - ROUND_SHIFT;
    localparam int SW     = (QW > AZ_W) ? QW : AZ_W;

    localparam logic [RW:0]   ROUND_HALF = (RW + 1)'(1) << (ROUND_SHIFT - 1);
    localparam logic [SW-1:0] AZ_LIM     = SW'(AZ_LIMIT_DEG) << PBA_ANGLE_FRAC_BITS;
    localparam logic [SW-1:0] EL_LIM     = SW'(EL_LIMIT_DEG) << PBA_ANGLE_FRAC_BITS;

    function automatic logic [SW-1:0] to_deg(input logic [PROD_W-1:0] prod,
                                             input logic neg,
                                             input logic [SW-1:0] limit);
        logic [RW:0]   rnd;
        logic [SW-1:0] q;
        rnd = {1'b0, prod, {PBA_ANGLE_FRAC_BITS{1'b0}}} + ROUND_HALF;
        q   = SW'(rnd[RW:ROUND_SHIFT]);
        if (q > limit) begin
            q = limit;
        end
        return neg ? -q : q;
    endfunction

    logic [ANG_W-1:0]  az_mag, el_mag;
    logic [PROD_W-1:0] r_az_prod, r_el_prod;
    logic              r_az_neg, r_el_neg, r_zero1, r_vld1;
    logic [SW-1:0]     n_az, n_el;
    logic [AZ_W-1:0]   r_az;
    logic [EL_W-1:0]   r_el;
    logic              r_zero, r_vld;

    assign az_mag = i_az[ANG_W-1] ? ANG_W'(-i_az) : ANG_W'(i_az);
    assign el_mag = i_el[ANG_W-1] ? ANG_W'(-i_el) : ANG_W'(i_el);
    assign n_az   = to_deg(r_az_prod, r_az_neg, AZ_LIM);
    assign n_el   = to_deg(r_el_prod, r_el_neg, EL_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld  <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_az_prod <= PROD_W'(az_mag) * PROD_W'(DEG_SCALE);
            r_el_prod <= PROD_W'(el_mag) * PROD_W'(DEG_SCALE);
            r_az_neg  <= i_az[ANG_W-1];
            r_el_neg  <= i_el[ANG_W-1];
            r_zero1   <= i_zero;

            r_az   <= n_az[AZ_W-1:0];
            r_el   <= n_el[EL_W-1:0];
            r_zero <= r_zero1;
        end
    end

    assign o_vld  = r_vld;
    assign o_az   = r_az;
    assign o_el   = r_el;
    assign o_zero = r_zero;

endmodule

// ===== rtl/point_bearing_angles.sv =====
// ----------------------------------------------------------------------------
// point_bearing_angles
// Azimuth atan2(x, z) and elevation atan2(y, sqrt(x*x + z*z)) of a point, in
// rounded signed degrees: Q9.8 azimuth, Q8.8 elevation (sign counted as integer).
// ----------------------------------------------------------------------------
// The block accepts one point per clock cycle unless the output stalls, and
// returns one result item per point, in order. The pipeline is made of the
// five front-end stages, the 31-stage bit-per-stage square root, the three
// normalisation stages and one stage per CORDIC micro-rotation, and the two
// degree-conversion stages. The whole pipeline advances together: it holds
// while a result waits and is not taken, and input ready is then low. The
// all-zero point gives zero angles with the zero_point flag set.
module point_bearing_angles
    import pba_pkg::*;
#(
    parameter int CORDIC_STAGES   = PBA_CORDIC_STAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pba_in_if.sink     i_pt,
    pba_out_if.source  o_res
);

    logic                    adv;
    logic                    prep_vld, sq_vld, az_vld, el_vld, az_zero, el_zero;
    t_side                   prep_side, sq_side;
    logic [SQ_IN_W-1:0]      prep_sum;
    logic [SQ_OUT_W-1:0]     sq_root;
    logic signed [ANG_W-1:0] az_ang, el_ang;

    assign adv        = !o_res.valid || o_res.ready;
    assign i_pt.ready = adv;

    pba_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (i_pt.valid),
        .i_x     (i_pt.point_x),
        .i_y     (i_pt.point_y),
        .i_z     (i_pt.point_z),
        .o_vld   (prep_vld),
        .o_side  (prep_side),
        .o_sum   (prep_sum)
    );

    pba_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (prep_vld),
        .i_rad   (prep_sum),
        .i_side  (prep_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    pba_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (sq_vld),
        .i_yv    (sq_side.az_y),
        .i_xv    (sq_side.az_x),
        .i_zero  (sq_side.zero),
        .o_vld   (az_vld),
        .o_ang   (az_ang),
        .o_zero  (az_zero)
    );

    pba_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_el (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (sq_vld),
        .i_yv    ({{(OP_W-NRM_W){sq_side.el_y[NRM_W-1]}}, sq_side.el_y}),
        .i_xv    ({{(OP_W-SQ_OUT_W){1'b0}}, sq_root}),
        .i_zero  (sq_side.zero),
        .o_vld   (el_vld),
        .o_ang   (el_ang),
        .o_zero  (el_zero)
    );

    pba_deg u_deg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (az_vld),
        .i_az    (az_ang),
        .i_el    (el_ang),
        .i_zero  (az_zero),
        .o_vld   (o_res.valid),
        .o_az    (o_res.azimuth_deg),
        .o_el    (o_res.elevation_deg),
        .o_zero  (o_res.zero_point)
    );

`ifndef ASSERT_OFF
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        az_vld == el_vld)
        else $error("azimuth and elevation lanes out of step");

    a_lanes_same_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        az_vld |-> az_zero == el_zero)
        else $error("azimuth and elevation lanes carry different items");

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_point |->
            o_res.azimuth_deg == '0 && o_res.elevation_deg == '0)
        else $error("zero point with non-zero angles");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_pt.ready)
        else $error("pipeline stalled with an empty result register");
`endif

endmodule
